### hdl/nwap_pkg.sv
// ----------------------------------------------------------------------------
// nwap_pkg: shared types and constants for the proximity averager
// Widths of the sample path, window length, register map and FSM states.
// ----------------------------------------------------------------------------
package nwap_pkg;

    // window length in samples (1 to 15)
    localparam int WINDOW = 10;

    // field and accumulator widths
    localparam int SMP_W  = 16;                  // sample / distance width
    localparam int SUM_W  = 20;                  // 15 * 65535 fits in 20 bits
    localparam int IDX_W  = 4;                   // sample index, up to 15
    localparam int NZC_W  = 4;                   // nonzero sample count
    localparam int STEP_W = $clog2(SUM_W);       // serial step counter

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int RIDX_W = ADDR_W - 2;          // word index in the map

    localparam logic [RIDX_W-1:0] REG_NEAR_THRESHOLD = RIDX_W'(0);
    localparam logic [SMP_W-1:0]  THR_RESET          = SMP_W'(60);

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,     // waiting for a sample
        S_ADD,      // bit-serial accumulate of one sample
        S_DIV,      // bit-serial restoring divide of the window sum
        S_EMIT      // load the result register
    } t_state;

endpackage

### hdl/nonzero_window_average_proximity.sv
// ----------------------------------------------------------------------------
// nonzero_window_average_proximity: windowed sonar average with near flag
// Averages the nonzero samples of each window bit-serially and emits the
// held distance, a near flag and a window-valid flag once per window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_sample) takes one sonar reading per
//   item. Every WINDOW items the block produces one result item on the output
//   channel (o_valid / i_ready / o_distance, o_near, o_window_valid); the
//   other items give no result.
//   A nonzero sample is added to the window sum one bit per cycle through a
//   20-bit shift register and a single full adder. At the window end, if the
//   window held a nonzero sample, a restoring divider, one quotient bit per
//   cycle, runs over the same shift register; then the result register is
//   loaded. One item is in work at a time.
//   The result register lets the next window start while a result waits; if
//   the receiver stalls, the block holds at the window end until the result
//   register frees up.
//   near_threshold (APB, byte address 0) is read at the window end.
//   Reset (synchronous, active low) clears the window, the held distance to
//   zero and sets near_threshold to 60. The block accepts items straight away.
// ----------------------------------------------------------------------------
module nonzero_window_average_proximity (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [nwap_pkg::SMP_W-1:0]    i_sample,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nwap_pkg::SMP_W-1:0]    o_distance,
    output logic                          o_near,
    output logic                          o_window_valid,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nwap_pkg::ADDR_W-1:0]   paddr,
    input  logic [nwap_pkg::DATA_W-1:0]   pwdata,
    output logic [nwap_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int SMP_W  = nwap_pkg::SMP_W;
    localparam int SUM_W  = nwap_pkg::SUM_W;
    localparam int IDX_W  = nwap_pkg::IDX_W;
    localparam int NZC_W  = nwap_pkg::NZC_W;
    localparam int STEP_W = nwap_pkg::STEP_W;

    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(nwap_pkg::WINDOW - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    // registers
    nwap_pkg::t_state     r_state, n_state;
    logic [IDX_W-1:0]     r_idx,   n_idx;
    logic [NZC_W-1:0]     r_nzc,   n_nzc;
    logic [SUM_W-1:0]     r_sum,   n_sum;
    logic [SMP_W-1:0]     r_smp,   n_smp;
    logic                 r_carry, n_carry;
    logic [NZC_W-1:0]     r_rem,   n_rem;
    logic [STEP_W-1:0]    r_cnt,   n_cnt;
    logic                 r_last,  n_last;
    logic [SMP_W-1:0]     r_held,  n_held;
    logic [SMP_W-1:0]     r_thr,   n_thr;
    logic                 r_out_valid, n_out_valid;
    logic [SMP_W-1:0]     r_out_dist,  n_out_dist;
    logic                 r_out_near,  n_out_near;
    logic                 r_out_wv,    n_out_wv;

    // handshake strobes
    logic                 in_take;
    logic                 out_take;
    logic                 out_free;
    logic                 cfg_wr;
    logic                 smp_nonzero;
    logic                 idx_end;
    logic                 step_end;
    logic                 emit_go;

    // serial adder and divider slices
    logic                 add_bit;
    logic                 add_carry;
    logic [NZC_W:0]       div_trial;
    logic [NZC_W:0]       div_diff;
    logic                 div_ge;
    logic                 win_valid;
    logic [SMP_W-1:0]     win_dist;

    // handshake and decode
    always_comb begin
        o_ready     = (r_state == nwap_pkg::S_IDLE);
        in_take     = i_valid && o_ready;
        out_take    = r_out_valid && i_ready;
        out_free    = !r_out_valid || i_ready;
        cfg_wr      = psel && penable && pwrite && pready;
        smp_nonzero = (i_sample != '0);
        idx_end     = (r_idx == IDX_LAST);
        step_end    = (r_cnt == STEP_LAST);
        emit_go     = (r_state == nwap_pkg::S_EMIT) && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nwap_pkg::S_IDLE: begin
                if (in_take) begin
                    if (smp_nonzero) begin
                        n_state = nwap_pkg::S_ADD;
                    end else if (idx_end) begin
                        n_state = (r_nzc != '0) ? nwap_pkg::S_DIV : nwap_pkg::S_EMIT;
                    end
                end
            end
            nwap_pkg::S_ADD: begin
                if (step_end) begin
                    n_state = r_last ? nwap_pkg::S_DIV : nwap_pkg::S_IDLE;
                end
            end
            nwap_pkg::S_DIV: begin
                if (step_end) begin
                    n_state = nwap_pkg::S_EMIT;
                end
            end
            nwap_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = nwap_pkg::S_IDLE;
                end
            end
            default: n_state = nwap_pkg::S_IDLE;
        endcase
    end

    // serial arithmetic slices
    always_comb begin
        // one full adder: sum LSB plus sample LSB
        add_bit   = r_sum[0] ^ r_smp[0] ^ r_carry;
        add_carry = (r_sum[0] & r_smp[0]) | (r_sum[0] & r_carry) | (r_smp[0] & r_carry);
        // one restoring divide step, dividend MSB first
        div_trial = {r_rem, r_sum[SUM_W-1]};
        div_diff  = div_trial - {1'b0, r_nzc};
        div_ge    = (div_trial >= {1'b0, r_nzc});
        // window result; r_sum holds the quotient here
        win_valid = (r_nzc != '0);
        win_dist  = (win_valid && (r_sum != '0)) ? r_sum[SMP_W-1:0] : r_held;
    end

    // datapath next values
    always_comb begin
        n_idx       = r_idx;
        n_nzc       = r_nzc;
        n_sum       = r_sum;
        n_smp       = r_smp;
        n_carry     = r_carry;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_held      = r_held;
        n_thr       = r_thr;
        n_out_valid = r_out_valid;
        n_out_dist  = r_out_dist;
        n_out_near  = r_out_near;
        n_out_wv    = r_out_wv;

        // result register drains
        if (out_take) begin
            n_out_valid = 1'b0;
        end

        // configuration write
        if (cfg_wr && (paddr[nwap_pkg::ADDR_W-1:2] == nwap_pkg::REG_NEAR_THRESHOLD)) begin
            n_thr = pwdata[SMP_W-1:0];
        end

        unique case (r_state)
            nwap_pkg::S_IDLE: begin
                if (in_take) begin
                    n_idx   = idx_end ? '0 : r_idx + IDX_W'(1);
                    n_last  = idx_end;
                    n_cnt   = '0;
                    n_carry = 1'b0;
                    n_rem   = '0;
                    if (smp_nonzero) begin
                        n_smp = i_sample;
                        n_nzc = r_nzc + NZC_W'(1);
                    end
                end
            end
            nwap_pkg::S_ADD: begin
                // rotate the sum through the adder, LSB first
                n_sum   = {add_bit, r_sum[SUM_W-1:1]};
                n_smp   = {1'b0, r_smp[SMP_W-1:1]};
                n_carry = add_carry;
                n_cnt   = step_end ? '0 : r_cnt + STEP_W'(1);
                n_rem   = '0;
            end
            nwap_pkg::S_DIV: begin
                // dividend bits leave at the top, quotient bits enter at the bottom
                n_sum = {r_sum[SUM_W-2:0], div_ge};
                n_rem = div_ge ? div_diff[NZC_W-1:0] : div_trial[NZC_W-1:0];
                n_cnt = step_end ? '0 : r_cnt + STEP_W'(1);
            end
            nwap_pkg::S_EMIT: begin
                if (out_free) begin
                    n_held      = win_dist;
                    n_out_valid = 1'b1;
                    n_out_dist  = win_dist;
                    n_out_near  = (win_dist < r_thr);
                    n_out_wv    = win_valid;
                    n_sum       = '0;
                    n_nzc       = '0;
                end
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nwap_pkg::S_IDLE;
            r_idx       <= '0;
            r_nzc       <= '0;
            r_sum       <= '0;
            r_last      <= 1'b0;
            r_cnt       <= '0;
            r_held      <= '0;
            r_thr       <= nwap_pkg::THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_nzc       <= n_nzc;
            r_sum       <= n_sum;
            r_last      <= n_last;
            r_cnt       <= n_cnt;
            r_held      <= n_held;
            r_thr       <= n_thr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_smp      <= n_smp;
        r_carry    <= n_carry;
        r_rem      <= n_rem;
        r_out_dist <= n_out_dist;
        r_out_near <= n_out_near;
        r_out_wv   <= n_out_wv;
    end

    // outputs
    assign o_valid        = r_out_valid;
    assign o_distance     = r_out_dist;
    assign o_near         = r_out_near;
    assign o_window_valid = r_out_wv;
    assign pready         = 1'b1;
    assign prdata         = (paddr[nwap_pkg::ADDR_W-1:2] == nwap_pkg::REG_NEAR_THRESHOLD)
                            ? {{(nwap_pkg::DATA_W-SMP_W){1'b0}}, r_thr} : '0;

    // checks
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nwap_pkg::S_DIV) |-> (r_nzc != '0))
        else $error("divide entered with an empty window");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nwap_pkg::S_DIV) |-> (r_rem < r_nzc))
        else $error("partial remainder not below divisor");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nwap_pkg::S_EMIT && r_nzc != '0) |-> (r_sum[SUM_W-1:SMP_W] == '0))
        else $error("window average wider than a sample");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= IDX_LAST))
        else $error("sample index beyond the window");

    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> (o_valid && (r_state == nwap_pkg::S_IDLE) && (r_nzc == '0)))
        else $error("result not loaded at the window end");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the proximity window averager
// Drives sonar readings through the valid/ready input channel, predicts
// each window result (held distance, near flag, window-valid flag) in a
// behavioural model and compares every result item field by field. The
// near threshold is written and read back over APB between phases, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    // shared constants
    localparam int WINDOW = nwap_pkg::WINDOW;
    localparam int SMP_W  = nwap_pkg::SMP_W;
    localparam int SUM_W  = nwap_pkg::SUM_W;
    localparam int IDX_W  = nwap_pkg::IDX_W;
    localparam int NZC_W  = nwap_pkg::NZC_W;
    localparam int ADDR_W = nwap_pkg::ADDR_W;
    localparam int DATA_W = nwap_pkg::DATA_W;

    localparam logic [nwap_pkg::RIDX_W-1:0] REG_NEAR_THRESHOLD = nwap_pkg::REG_NEAR_THRESHOLD;
    localparam logic [SMP_W-1:0]            THR_RESET          = nwap_pkg::THR_RESET;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 60;       // longer than the longest item in work
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 108;      // not a multiple of WINDOW
    localparam int NUM_PHASES    = 6;

    localparam logic [ADDR_W-1:0] THR_ADDR      = ADDR_W'({REG_NEAR_THRESHOLD, 2'b00});
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);

    // how the samples of one window are drawn
    typedef enum logic [2:0] {
        STY_ZERO,       // no echo at all
        STY_SPARSE,     // mostly zero, a few full-range readings
        STY_FULL,       // full-range readings
        STY_AT_THR,     // readings just around the threshold
        STY_SHORT,      // short range with some dropouts
        STY_TOP         // readings at the top of the range
    } t_win_style;

    typedef struct packed {
        logic [SMP_W-1:0] distance;
        logic             near;
        logic             wvalid;
    } t_window_result;

    // DUT ports
    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [SMP_W-1:0]  i_sample;
    logic              o_valid;
    logic              i_ready;
    logic [SMP_W-1:0]  o_distance;
    logic              o_near;
    logic              o_window_valid;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // model state
    logic [IDX_W-1:0]  smp_count;
    logic [SUM_W-1:0]  win_sum;
    logic [NZC_W-1:0]  nz_count;
    logic [SMP_W-1:0]  held_dist;
    logic [SMP_W-1:0]  thr_model;

    t_window_result    pending_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int items_sent;
    int results_checked;
    int thr_writes;
    int cycle_count;

    nonzero_window_average_proximity DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_distance     (o_distance),
        .o_near         (o_near),
        .o_window_valid (o_window_valid),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // window average model
    // ------------------------------------------------------------------------

    function automatic void clear_model();
        smp_count = '0;
        win_sum   = '0;
        nz_count  = '0;
        held_dist = '0;
        thr_model = THR_RESET;
    endfunction

    // accumulate one accepted item; at the window end queue the result
    function automatic void predict_window_result(logic [SMP_W-1:0] smp);
        t_window_result   res;
        logic [SUM_W-1:0] avg;
        if (smp != '0) begin
            win_sum  = win_sum + SUM_W'(smp);
            nz_count = nz_count + 1'b1;
        end
        smp_count = smp_count + 1'b1;
        if (smp_count == IDX_W'(WINDOW)) begin
            res.wvalid = (nz_count != '0);
            if (res.wvalid) begin
                avg = win_sum / SUM_W'(nz_count);
                if (avg != '0)
                    held_dist = avg[SMP_W-1:0];
            end
            res.distance = held_dist;
            res.near     = (held_dist < thr_model);
            pending_results.push_back(res);
            smp_count = '0;
            win_sum   = '0;
            nz_count  = '0;
        end
    endfunction

    function automatic void note_mismatch(string what, longint unsigned exp_v,
                                          longint unsigned act_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
                     error_count, cycle_count, what, exp_v, act_v);
    endfunction

    // ------------------------------------------------------------------------
    // result channel: random stall and checker
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (i_rst_n)
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_window_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result, distance", 0, o_distance);
            end else begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (o_distance !== exp_r.distance)
                    note_mismatch("distance", exp_r.distance, o_distance);
                if (o_near !== exp_r.near)
                    note_mismatch("near", exp_r.near, o_near);
                if (o_window_valid !== exp_r.wvalid)
                    note_mismatch("window_valid", exp_r.wvalid, o_window_valid);
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared driver tasks
    // ------------------------------------------------------------------------

    // offer one item; valid is left high so back-to-back items need no dip
    task automatic send_sample(input logic [SMP_W-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_sample = smp;
        do @(posedge i_clk); while (!o_ready);
        predict_window_result(smp);
        items_sent++;
    endtask

    // drop valid, wait for every expected result, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[ADDR_W-1:2] == REG_NEAR_THRESHOLD)
            thr_model = data[SMP_W-1:0];
        thr_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_threshold();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = THR_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(thr_model))
            note_mismatch("near_threshold readback", thr_model, prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // threshold reset value and a first window with no echo at all
    task automatic test_reset_defaults();
        apb_read_threshold();
        repeat (WINDOW) send_sample('0);
        wait_idle();
    endtask

    // full-scale readings with one dropout: average is the maximum
    task automatic test_field_extremes();
        repeat (WINDOW - 1) send_sample('1);
        send_sample('0);
        wait_idle();
    endtask

    // threshold changed halfway through a window, truncating average of 3/2
    task automatic test_threshold_mid_window();
        send_sample('0);
        send_sample(SMP_W'(1));
        send_sample(SMP_W'(2));
        send_sample('0);
        send_sample('0);
        wait_idle();
        apb_write(THR_ADDR, 32'hABCD_FFFF);      // upper bits are dropped
        apb_write(UNMAPPED_ADDR, 32'h0000_0005); // no register there
        apb_read_threshold();
        repeat (WINDOW - 5) send_sample('0);
        wait_idle();
    endtask

    // random windows over several thresholds and idling patterns
    task automatic test_random_traffic();
        t_win_style       style;
        int               base;
        int               pick;
        logic [SMP_W-1:0] smp;
        logic [SMP_W-1:0] new_thr;
        style = STY_FULL;
        base  = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 34;
                recv_idle_pct = 47;
            end else if (ph < 4) begin
                send_idle_pct = 47;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            unique case (ph)
                0:       new_thr = '0;
                1:       new_thr = '1;
                2:       new_thr = SMP_W'($urandom);
                3:       new_thr = SMP_W'(1);
                4:       new_thr = SMP_W'($urandom_range(1, 2000));
                default: new_thr = THR_RESET;
            endcase
            apb_write(THR_ADDR, {DATA_W'($urandom) & ~DATA_W'({SMP_W{1'b1}})} | new_thr);
            apb_read_threshold();

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // choose how this window is filled at its first sample
                if (smp_count == '0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)       style = STY_ZERO;
                    else if (pick < 23) style = STY_SPARSE;
                    else if (pick < 48) style = STY_FULL;
                    else if (pick < 63) style = STY_AT_THR;
                    else if (pick < 88) style = STY_SHORT;
                    else                style = STY_TOP;
                    base = int'(thr_model) + $urandom_range(0, 2) - 1;
                    if (base < 0)     base = 0;
                    if (base > 65535) base = 65535;
                end
                unique case (style)
                    STY_ZERO:   smp = '0;
                    STY_SPARSE: smp = ($urandom_range(0, 99) < 80) ? '0 : SMP_W'($urandom);
                    STY_FULL:   smp = SMP_W'($urandom);
                    STY_AT_THR: smp = SMP_W'(base);
                    STY_SHORT:  smp = ($urandom_range(0, 99) < 20) ? '0
                                      : SMP_W'($urandom_range(1, 255));
                    default:    smp = SMP_W'(65535 - $urandom_range(0, 3));
                endcase
                send_sample(smp);
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        items_sent    = 0;
        results_checked = 0;
        thr_writes    = 0;
        send_idle_pct = 34;
        recv_idle_pct = 47;
        clear_model();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_threshold_mid_window();
        test_random_traffic();

        wait_idle();
        $display("covered %0d samples, %0d window results, %0d threshold writes",
                 items_sent, results_checked, thr_writes);
        $display("zero windows, dropouts, full-scale and near-threshold readings, mismatches: %0d",
                 error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### nonzero_window_average_proximity.f
hdl/nwap_pkg.sv
hdl/nonzero_window_average_proximity.sv
tb/sv/testbench.sv
